[rtl/stc_pkg.sv]
// ----------------------------------------------------------------------------
// stc_pkg
// Shared constants and types for the scope trigger capture block.
// ----------------------------------------------------------------------------
package stc_pkg;

  // averaging and frame geometry
  localparam int SAMPLES_PER_POINT = 16;
  localparam int POINTS_PER_FRAME  = 480;

  // field widths
  localparam int SAMPLE_W = 12;
  localparam int AVG_W    = 12;
  localparam int LEVEL_W  = 12;
  localparam int ROW_W    = 9;
  localparam int INDEX_W  = 9;
  localparam int DROP_W   = 8;

  // derived storage widths
  localparam int CNT_W = (SAMPLES_PER_POINT > 1) ? $clog2(SAMPLES_PER_POINT) : 1;
  localparam int ACC_W = SAMPLE_W + $clog2(SAMPLES_PER_POINT);
  localparam int POS_W = $clog2(POINTS_PER_FRAME);

  // level = floor(avg * 0.82), exact for any 12 bit average
  localparam int LEVEL_MUL   = 859833;
  localparam int LEVEL_SHIFT = 20;
  localparam int LEVEL_PROD_W = 32;

  // drop = floor(avg / 18), exact for any 12 bit average
  localparam int DROP_MUL    = 3641;
  localparam int DROP_SHIFT  = 16;
  localparam int DROP_PROD_W = 24;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_LEVEL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BASELINE_ROW  = 2'd1;
  localparam int CFG_DATA_W = 12;

  // register reset values
  localparam logic [LEVEL_W-1:0] TRIGGER_RESET  = 12'd1650;
  localparam logic [ROW_W-1:0]   BASELINE_RESET = 9'd275;

  // stream widths
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 48;

  // averaged point handed from the accumulator to the point stage
  typedef struct packed {
    logic             valid;
    logic [AVG_W-1:0] avg;
  } avg_beat_t;

endpackage

[rtl/stc_accum.sv]
// ----------------------------------------------------------------------------
// stc_accum
// Sums raw samples into groups and registers the averaged point.
// ----------------------------------------------------------------------------
module stc_accum (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         sample_valid,
  output logic                         sample_ready,
  input  logic [stc_pkg::SAMPLE_W-1:0] sample,
  output stc_pkg::avg_beat_t           avg_beat,
  input  logic                         avg_ready
);
  import stc_pkg::*;

  logic [ACC_W-1:0] sum_r, sum_nxt;
  logic [CNT_W-1:0] count_r;
  logic             avg_valid_r;
  logic [AVG_W-1:0] avg_r;
  logic             accept;
  logic             group_done;
  logic [ACC_W-1:0] avg_full;

  // a new sample is taken unless a finished point is stuck downstream
  assign sample_ready = !avg_valid_r || avg_ready;
  assign accept       = sample_valid && sample_ready;

  assign sum_nxt    = sum_r + ACC_W'(sample);
  assign group_done = (count_r == CNT_W'(SAMPLES_PER_POINT - 1));
  assign avg_full   = ACC_W'(sum_nxt / SAMPLES_PER_POINT);

  // accumulator and point register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r       <= '0;
      count_r     <= '0;
      avg_valid_r <= 1'b0;
    end else begin
      if (avg_valid_r && avg_ready) begin
        avg_valid_r <= 1'b0;
      end
      if (accept) begin
        if (group_done) begin
          sum_r       <= '0;
          count_r     <= '0;
          avg_valid_r <= 1'b1;
        end else begin
          sum_r   <= sum_nxt;
          count_r <= count_r + CNT_W'(1);
        end
      end
    end
  end

  // averaged value payload
  always_ff @(posedge clk) begin
    if (accept && group_done) begin
      avg_r <= AVG_W'(avg_full);
    end
  end

  assign avg_beat.valid = avg_valid_r;
  assign avg_beat.avg   = avg_r;

endmodule

[rtl/stc_point.sv]
// ----------------------------------------------------------------------------
// stc_point
// Scales an averaged point, tracks the peak, runs the trigger search and
// frame capture, and holds the result register.
// ----------------------------------------------------------------------------
module stc_point (
  input  logic                         clk,
  input  logic                         rst_n,
  input  stc_pkg::avg_beat_t           avg_beat,
  output logic                         avg_ready,
  input  logic [stc_pkg::LEVEL_W-1:0]  trigger_level,
  input  logic [stc_pkg::ROW_W-1:0]    baseline_row,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [stc_pkg::INDEX_W-1:0]  point_index,
  output logic [stc_pkg::ROW_W-1:0]    trace_row,
  output logic [stc_pkg::LEVEL_W-1:0]  level_mv,
  output logic [stc_pkg::LEVEL_W-1:0]  peak_level_mv,
  output logic                         frame_end
);
  import stc_pkg::*;

  logic                    capturing_r;
  logic                    have_prev_r;
  logic                    prev_below_r;
  logic [POS_W-1:0]        pos_r;
  logic [LEVEL_W-1:0]      peak_r, peak_nxt;
  logic                    out_valid_r;
  logic [INDEX_W-1:0]      index_r;
  logic [ROW_W-1:0]        row_r;
  logic [LEVEL_W-1:0]      level_r;
  logic [LEVEL_W-1:0]      peak_out_r;
  logic                    last_r;

  logic                    go;
  logic [LEVEL_PROD_W-1:0] level_prod;
  logic [DROP_PROD_W-1:0]  drop_prod;
  logic [LEVEL_W-1:0]      level;
  logic [DROP_W-1:0]       drop;
  logic [ROW_W-1:0]        row;
  logic                    below;
  logic                    last;
  logic [31:0]             pos_ext;

  // searching points never wait on the output side
  assign avg_ready = !capturing_r || !out_valid_r || out_ready;
  assign go        = avg_beat.valid && avg_ready;

  // constant scaling by reciprocal multiply
  assign level_prod = LEVEL_PROD_W'(avg_beat.avg) * LEVEL_PROD_W'(LEVEL_MUL);
  assign level      = LEVEL_W'(level_prod >> LEVEL_SHIFT);
  assign drop_prod  = DROP_PROD_W'(avg_beat.avg) * DROP_PROD_W'(DROP_MUL);
  assign drop       = DROP_W'(drop_prod >> DROP_SHIFT);
  assign row        = (baseline_row > ROW_W'(drop)) ? (baseline_row - ROW_W'(drop)) : '0;

  assign peak_nxt = (level > peak_r) ? level : peak_r;
  assign below    = (level < trigger_level);
  assign last     = (pos_r == POS_W'(POINTS_PER_FRAME - 1));
  assign pos_ext  = 32'(pos_r);

  // trigger search, frame position and peak
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capturing_r  <= 1'b0;
      have_prev_r  <= 1'b0;
      prev_below_r <= 1'b0;
      pos_r        <= '0;
      peak_r       <= '0;
    end else if (go) begin
      peak_r <= peak_nxt;
      if (!capturing_r) begin
        if (have_prev_r && prev_below_r && !below) begin
          capturing_r <= 1'b1;
          pos_r       <= '0;
          have_prev_r <= 1'b0;
        end else begin
          have_prev_r  <= 1'b1;
          prev_below_r <= below;
        end
      end else if (last) begin
        capturing_r  <= 1'b0;
        have_prev_r  <= 1'b0;
        prev_below_r <= 1'b0;
        pos_r        <= '0;
      end else begin
        pos_r <= pos_r + POS_W'(1);
      end
    end
  end

  // result register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (go && capturing_r) begin
        out_valid_r <= 1'b1;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (go && capturing_r) begin
      index_r    <= pos_ext[INDEX_W-1:0];
      row_r      <= row;
      level_r    <= level;
      peak_out_r <= peak_nxt;
      last_r     <= last;
    end
  end

  assign out_valid     = out_valid_r;
  assign point_index   = index_r;
  assign trace_row     = row_r;
  assign level_mv      = level_r;
  assign peak_level_mv = peak_out_r;
  assign frame_end     = last_r;

`ifndef NO_ASSERTIONS
  // frame end only once the position has wrapped back to zero
  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && last_r) |-> (pos_ext[INDEX_W-1:0] == '0))
    else $error("frame end without position back at zero");

  // reported peak covers the reported level
  a_peak_cover: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (peak_out_r >= level_r))
    else $error("peak below level");

  // no result is produced while searching
  a_search_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (!capturing_r && out_ready) |=> !out_valid_r)
    else $error("result while searching");

  // frame position rests at zero while searching
  a_pos_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !capturing_r |-> (pos_r == '0))
    else $error("frame position moved while searching");
`endif

endmodule

[rtl/scope_trigger_capture.sv]
// ----------------------------------------------------------------------------
// scope_trigger_capture
// Rising-edge triggered capture of averaged converter points.
// ----------------------------------------------------------------------------
// One raw sample is taken per clock. Every 16 samples form one averaged point
// (sum / 16), registered in the accumulator; once it is taken, the point stage
// scales it (level = floor(avg * 0.82), row = baseline - avg / 18, clamped at
// zero), raises the peak and runs the trigger search, writing a result into the
// output register. After two consecutive points that cross the trigger level
// upward, the next 480 points are sent out with their index, tlast on the last
// one, and the search starts again. Each result is registered in the accumulator's
// point register, then in the output register. Input stalls only when a finished
// point meets an output register whose beat has not been taken; configuration
// writes are always accepted and should be made while the block is idle.
// ----------------------------------------------------------------------------
module scope_trigger_capture (
  input  logic                             clk,
  input  logic                             rst_n,
  // input samples, tdata: adc_sample[11:0]
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [stc_pkg::IN_TDATA_W-1:0]   in_tdata,
  // results, tdata: point_index[8:0], trace_row[17:9], level_mv[29:18],
  // peak_level_mv[41:30]; tlast: frame_end
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [stc_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic                             out_tlast,
  // configuration writes
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [stc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [stc_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import stc_pkg::*;

  logic [LEVEL_W-1:0] trigger_r;
  logic [ROW_W-1:0]   baseline_r;
  avg_beat_t          avg_beat;
  logic               avg_ready;
  logic [INDEX_W-1:0] point_index;
  logic [ROW_W-1:0]   trace_row;
  logic [LEVEL_W-1:0] level_mv;
  logic [LEVEL_W-1:0] peak_level_mv;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trigger_r  <= TRIGGER_RESET;
      baseline_r <= BASELINE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_TRIGGER_LEVEL: trigger_r  <= cfg_data[LEVEL_W-1:0];
        CFG_BASELINE_ROW:  baseline_r <= cfg_data[ROW_W-1:0];
        default: ;
      endcase
    end
  end

  // sample accumulation
  stc_accum u_accum (
    .clk          (clk),
    .rst_n        (rst_n),
    .sample_valid (in_tvalid),
    .sample_ready (in_tready),
    .sample       (in_tdata[SAMPLE_W-1:0]),
    .avg_beat     (avg_beat),
    .avg_ready    (avg_ready)
  );

  // scaling, trigger and result register
  stc_point u_point (
    .clk           (clk),
    .rst_n         (rst_n),
    .avg_beat      (avg_beat),
    .avg_ready     (avg_ready),
    .trigger_level (trigger_r),
    .baseline_row  (baseline_r),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .point_index   (point_index),
    .trace_row     (trace_row),
    .level_mv      (level_mv),
    .peak_level_mv (peak_level_mv),
    .frame_end     (out_tlast)
  );

  // result beat packing
  assign out_tdata = {6'd0, peak_level_mv, level_mv, trace_row, point_index};

endmodule

[verif/capture_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// capture_checker
// Watches the sample, result and register channels of the trigger capture
// block, keeps its own copy of the averaging and trigger search state, and
// compares every result beat field by field with the oldest predicted point.
// ----------------------------------------------------------------------------
module capture_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [stc_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [stc_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                            out_tlast,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [stc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [stc_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                              error_count,
  output int                              outstanding
);
  import stc_pkg::*;

  // one captured point as it leaves the block
  typedef struct packed {
    logic [INDEX_W-1:0] pos;
    logic [ROW_W-1:0]   row;
    logic [LEVEL_W-1:0] level;
    logic [LEVEL_W-1:0] peak;
    logic               last;
  } capture_point_t;

  capture_point_t expected_points[$];

  // register copies
  logic [LEVEL_W-1:0] trig_mv;
  logic [ROW_W-1:0]   base_row;

  // averaging and search state
  logic [ACC_W-1:0]   acc_sum;
  int                 acc_count;
  logic               in_frame;
  logic               prev_valid;
  logic               prev_low;
  int                 frame_idx;
  logic [LEVEL_W-1:0] peak_mv;

  int mismatches = 0;
  int pending_n  = 0;

  assign error_count = mismatches;
  assign outstanding = pending_n;

  // fold one sample into the running average, predict the point it may finish
  task automatic take_sample(input logic [SAMPLE_W-1:0] sample);
    int             avg;
    int             lvl;
    int             drop;
    capture_point_t pt;
    acc_sum = acc_sum + ACC_W'(sample);
    acc_count++;
    if (acc_count < SAMPLES_PER_POINT) return;

    avg       = int'(acc_sum) / SAMPLES_PER_POINT;
    acc_sum   = '0;
    acc_count = 0;

    lvl  = (avg * 82) / 100;
    if (lvl > 4095) lvl = 4095;
    drop = avg / 18;
    if (lvl > int'(peak_mv)) peak_mv = LEVEL_W'(lvl);

    // search: a point below the level followed by one at or above it
    if (!in_frame) begin
      if (prev_valid && prev_low && lvl >= int'(trig_mv)) begin
        in_frame   = 1'b1;
        frame_idx  = 0;
        prev_valid = 1'b0;
      end else begin
        prev_valid = 1'b1;
        prev_low   = (lvl < int'(trig_mv));
      end
      return;
    end

    pt.pos   = INDEX_W'(frame_idx);
    pt.row   = (int'(base_row) > drop) ? ROW_W'(int'(base_row) - drop) : '0;
    pt.level = LEVEL_W'(lvl);
    pt.peak  = peak_mv;
    pt.last  = (frame_idx >= POINTS_PER_FRAME - 1);
    expected_points.push_back(pt);

    // frame done: back to searching with no previous point
    if (pt.last) begin
      in_frame   = 1'b0;
      prev_valid = 1'b0;
      prev_low   = 1'b0;
      frame_idx  = 0;
    end else begin
      frame_idx++;
    end
  endtask

  always @(posedge clk) begin
    capture_point_t want;
    capture_point_t got;
    if (!rst_n) begin
      trig_mv    = TRIGGER_RESET;
      base_row   = BASELINE_RESET;
      acc_sum    = '0;
      acc_count  = 0;
      in_frame   = 1'b0;
      prev_valid = 1'b0;
      prev_low   = 1'b0;
      frame_idx  = 0;
      peak_mv    = '0;
      expected_points.delete();
    end else begin
      // result beat against the oldest prediction
      if (out_tvalid && out_tready) begin
        got.pos   = out_tdata[8:0];
        got.row   = out_tdata[17:9];
        got.level = out_tdata[29:18];
        got.peak  = out_tdata[41:30];
        got.last  = out_tlast;
        if (expected_points.size() == 0) begin
          $error("unexpected result beat: point_index %0d level_mv %0d", got.pos, got.level);
          mismatches++;
        end else begin
          want = expected_points.pop_front();
          if (got.pos != want.pos) begin
            $error("point_index: expected %0d, got %0d", want.pos, got.pos);
            mismatches++;
          end
          if (got.row != want.row) begin
            $error("trace_row: expected %0d, got %0d", want.row, got.row);
            mismatches++;
          end
          if (got.level != want.level) begin
            $error("level_mv: expected %0d, got %0d", want.level, got.level);
            mismatches++;
          end
          if (got.peak != want.peak) begin
            $error("peak_level_mv: expected %0d, got %0d", want.peak, got.peak);
            mismatches++;
          end
          if (got.last != want.last) begin
            $error("frame_end: expected %0d, got %0d", want.last, got.last);
            mismatches++;
          end
        end
      end

      // register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_TRIGGER_LEVEL: trig_mv = cfg_data[LEVEL_W-1:0];
          CFG_BASELINE_ROW:  base_row = cfg_data[ROW_W-1:0];
          default: ;
        endcase
      end

      // sample beat
      if (in_tvalid && in_tready) take_sample(in_tdata[SAMPLE_W-1:0]);
    end
    pending_n <= expected_points.size();
  end

endmodule

[verif/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus for the trigger capture block: corner samples, then whole averaged
// points built around chosen levels so that rising edges occur and frames start,
// mixed with noise and misaligned bursts, under several register settings and
// with random stalls on both streams. The checker decides pass or fail.
// ----------------------------------------------------------------------------
module testbench;
  import stc_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 16;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index  = CFG_TRIGGER_LEVEL;
  logic [CFG_DATA_W-1:0]  cfg_data   = '0;

  int error_count;
  int outstanding;

  int send_idle    = 0;
  int recv_idle    = 0;
  bit send_calm    = 1'b0;
  bit recv_calm    = 1'b0;
  int recv_stretch = 0;
  int frames_done  = 0;
  int quiet_cycles = 0;
  int trig_now     = int'(TRIGGER_RESET);

  scope_trigger_capture i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  capture_checker i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .error_count (error_count),
    .outstanding (outstanding)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // result side: random stalls, with calm stretches now and then
  always @(posedge clk) begin
    if (recv_stretch == 0) begin
      recv_stretch <= $urandom_range(20, 120);
      recv_calm    <= ($urandom_range(0, 3) == 0);
    end else begin
      recv_stretch <= recv_stretch - 1;
    end
    out_tready <= rst_n && (recv_calm || $urandom_range(0, 99) >= recv_idle);
  end

  // frame count and watchdog on beat-free cycles
  always @(posedge clk) begin
    if (out_tvalid && out_tready && out_tlast) frames_done <= frames_done + 1;
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  // one sample beat, with random gaps unless in a calm stretch
  task automatic send_sample(input logic [SAMPLE_W-1:0] s);
    while (!send_calm && $urandom_range(0, 99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_TDATA_W'(s);
    do @(posedge clk); while (!in_tready);
  endtask

  // sixteen samples whose mean is exactly the given average
  task automatic send_point(input int avg);
    int spread;
    int d;
    spread = (avg < 4095 - avg) ? avg : 4095 - avg;
    for (int k = 0; k < SAMPLES_PER_POINT / 2; k++) begin
      d = $urandom_range(0, spread);
      send_sample(SAMPLE_W'(avg + d));
      send_sample(SAMPLE_W'(avg - d));
    end
  endtask

  // stop sending until every predicted point is out, then let the pipe settle
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // both registers, one held-high write burst
  task automatic configure(input int trig, input int base);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_TRIGGER_LEVEL;
    cfg_data  <= CFG_DATA_W'(trig);
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= CFG_BASELINE_ROW;
    cfg_data  <= CFG_DATA_W'(base);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    trig_now = trig;
  endtask

  // random points around the trigger level until enough samples and frames
  task automatic run_phase(input int quota, input int frames_needed);
    int  sent;
    int  goal;
    int  pause_at;
    int  ta;
    int  kind;
    int  n;
    bit  paused;
    sent     = 0;
    paused   = 1'b0;
    goal     = frames_done + frames_needed;
    pause_at = $urandom_range(64, quota);
    // smallest average whose level reaches the trigger
    ta = (trig_now * 100 + 81) / 82;
    while (sent < quota || frames_done < goal) begin
      send_calm = ($urandom_range(0, 4) == 0);
      kind = $urandom_range(0, 99);
      n    = SAMPLES_PER_POINT;
      if (kind < 40 && ta > 0) begin
        send_point($urandom_range(0, ta - 1));
      end else if (kind < 80) begin
        send_point($urandom_range(ta, 4095));
      end else if (kind < 88) begin
        // right at the threshold
        send_point((kind < 84 && ta > 0) ? ta - 1 : ta);
      end else if (kind < 94) begin
        send_point($urandom_range(0, 1) ? 4095 : 0);
      end else begin
        // noise point, or a short burst that shifts the point alignment
        if (kind >= 97) n = $urandom_range(1, SAMPLES_PER_POINT - 1);
        repeat (n) send_sample(SAMPLE_W'($urandom_range(0, 4095)));
      end
      sent += n;
      if (!paused && sent >= pause_at) begin
        paused = 1'b1;
        drain();
      end
    end
  endtask

  initial begin
    send_idle = 32;
    recv_idle = 85;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // corner samples: extremes and alternating bit patterns
    send_sample(12'h000);
    send_sample(12'hFFF);
    send_sample(12'hAAA);
    send_sample(12'h555);
    send_sample(12'h800);
    send_sample(12'h7FF);
    send_sample(12'h001);
    send_sample(12'hFFE);
    repeat (16) send_sample(12'h000);

    // reset settings, sender light, receiver heavy
    run_phase(260, 0);
    drain();

    // highest trigger and baseline, sender heavy, receiver light
    send_idle = 85;
    recv_idle = 32;
    configure(3357, 511);
    run_phase(280, 0);
    drain();

    // zero trigger never fires, zero baseline clamps every row
    send_idle = 0;
    recv_idle = 0;
    configure(0, 0);
    run_phase(260, 0);
    drain();

    // random mid trigger, low baseline
    configure($urandom_range(200, 3300), $urandom_range(0, 120));
    run_phase(260, 0);
    drain();

    if (error_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
